>>> sv/buddy_page_allocator_top_defines.svh
// Assertion macros shared by the buddy page allocator checker.
`ifndef BUDDY_PAGE_ALLOCATOR_TOP_DEFINES_SVH
`define BUDDY_PAGE_ALLOCATOR_TOP_DEFINES_SVH

// Same-cycle implication, sampled on aclk and switched off while aresetn is low.
`define BPA_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk and switched off while aresetn is low.
`define BPA_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/bpa_pkg.sv
// Shared constants for the buddy page allocator.
`timescale 1ns / 1ps
`default_nettype none

package bpa_pkg;

    // Default tree geometry.
    localparam int DEF_TREE_LEVELS = 9;
    localparam int DEF_PAGE_BYTES  = 4096;

    // Field widths.
    localparam int REQ_W      = 21;
    localparam int ADDR_W     = 32;
    localparam int S_TDATA_W  = 56;

    // Pool base after reset.
    localparam logic [ADDR_W-1:0] POOL_BASE_RESET = 32'h0010_0000;

    // Operation codes carried in s_tuser.
    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    // Node state codes.
    localparam logic [1:0] ST_DARK  = 2'd0;
    localparam logic [1:0] ST_FREE  = 2'd1;
    localparam logic [1:0] ST_SPLIT = 2'd2;
    localparam logic [1:0] ST_USED  = 2'd3;

endpackage

`default_nettype wire

>>> sv/buddy_page_allocator_top.sv
// Buddy page allocator: node-state memory with a read-modify-write sequencer.
//
//  Channel   Direction  Payload
//  s_        in         tuser: func; tdata: req_size[20:0], block_addr[52:21]
//  m_        out        tuser: ok; tdata: result_addr[31:0]
//  cfg_wr_   in         pool_base, written whenever cfg_wr_en is high
//
// One transaction is handled at a time. Every node visit reads the memory, then
// evaluates; a split adds two writes, each backtrack step moves to the sibling or
// climbs, and each merge level reads and evaluates the buddy, darkens the buddy and
// the node and frees the parent. A refused request goes from acceptance straight to
// hand-over. After reset a clearing pass sweeps all 2**TREE_LEVELS entries (512 by
// default) of the memory while s_tready stays low. A waiting result is held in the
// output register while the next transaction is taken; a full output stalls only
// the final hand-over.
`timescale 1ns / 1ps
`default_nettype none

module buddy_page_allocator_top #(
    parameter int TREE_LEVELS = bpa_pkg::DEF_TREE_LEVELS,
    parameter int PAGE_BYTES  = bpa_pkg::DEF_PAGE_BYTES
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // Configuration
    input  wire logic                           cfg_wr_en,
    input  wire logic [bpa_pkg::ADDR_W-1:0]     cfg_wr_data,
    // Request stream
    input  wire logic                           s_tvalid,
    output      logic                           s_tready,
    input  wire logic [bpa_pkg::S_TDATA_W-1:0]  s_tdata,   // req_size, block_addr, zero pad
    input  wire logic                           s_tuser,   // func
    // Result stream
    output      logic                           m_tvalid,
    input  wire logic                           m_tready,
    output      logic [bpa_pkg::ADDR_W-1:0]     m_tdata,   // result_addr
    output      logic                           m_tuser    // ok
);

    localparam int NODE_AW    = TREE_LEVELS;
    localparam int MEM_DEPTH  = 1 << TREE_LEVELS;
    localparam int DEPTH_W    = $clog2(TREE_LEVELS);
    localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
    localparam int POOL_SHIFT = PAGE_SHIFT + TREE_LEVELS - 1;
    localparam logic [32:0] POOL_BYTES = 33'(PAGE_BYTES) << (TREE_LEVELS - 1);
    localparam logic [31:0] POOL_MASK  = 32'(POOL_BYTES - 33'd1);
    localparam logic [DEPTH_W-1:0] LEAF_DEPTH = DEPTH_W'(TREE_LEVELS - 1);
    localparam logic [NODE_AW-1:0] ROOT_NODE  = NODE_AW'(1);

    // Sequencer states.
    localparam logic [3:0] S_CLR  = 4'd0;
    localparam logic [3:0] S_IDLE = 4'd1;
    localparam logic [3:0] S_ARD  = 4'd2;
    localparam logic [3:0] S_AEV  = 4'd3;
    localparam logic [3:0] S_ASPL = 4'd4;
    localparam logic [3:0] S_ASPR = 4'd5;
    localparam logic [3:0] S_ABT  = 4'd6;
    localparam logic [3:0] S_FRD  = 4'd7;
    localparam logic [3:0] S_FEV  = 4'd8;
    localparam logic [3:0] S_MRD  = 4'd9;
    localparam logic [3:0] S_MEV  = 4'd10;
    localparam logic [3:0] S_MDK  = 4'd11;
    localparam logic [3:0] S_MUP  = 4'd12;
    localparam logic [3:0] S_DONE = 4'd13;

    logic [3:0]                   state_reg, state_next;
    logic [NODE_AW-1:0]           clr_reg, clr_next;
    logic [NODE_AW-1:0]           node_reg, node_next;
    logic [DEPTH_W-1:0]           depth_reg, depth_next;
    logic [DEPTH_W-1:0]           tgt_reg, tgt_next;
    logic [31:0]                  off_reg, off_next;
    logic [31:0]                  res_addr_reg, res_addr_next;
    logic                         res_ok_reg, res_ok_next;
    logic                         m_valid_reg, m_valid_next;
    logic [31:0]                  m_addr_reg, m_addr_next;
    logic                         m_ok_reg, m_ok_next;
    logic [31:0]                  pool_base_reg, pool_base_next;
    logic [1:0]                   rd_reg;

    logic                         mem_we, mem_re;
    logic [NODE_AW-1:0]           mem_waddr, mem_raddr;
    logic [1:0]                   mem_wdata;
    logic [1:0]                   node_mem [0:MEM_DEPTH-1];

    logic [bpa_pkg::REQ_W-1:0]    in_req;
    logic [31:0]                  in_addr;
    logic [31:0]                  in_off;
    logic [DEPTH_W-1:0]           size_log;
    logic [NODE_AW-1:0]           page_idx;
    logic [31:0]                  blk_off;
    logic                         blk_aligned;
    logic [31:0]                  off_sh;

    assign in_req  = s_tdata[bpa_pkg::REQ_W-1:0];
    assign in_addr = s_tdata[bpa_pkg::REQ_W+31:bpa_pkg::REQ_W];
    assign in_off  = in_addr - pool_base_reg;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_addr_reg;
    assign m_tuser  = m_ok_reg;

    // Smallest block size, in pages as a power of two, that holds the request.
    always_comb begin
        size_log = LEAF_DEPTH;
        for (int i = TREE_LEVELS - 1; i >= 0; i--) begin
            if ((33'(PAGE_BYTES) << i) >= 33'(in_req)) begin
                size_log = DEPTH_W'(i);
            end
        end
    end

    // Byte offset of the current node: its index moved to leaf level, top bit dropped.
    assign page_idx = node_reg << (LEAF_DEPTH - depth_reg);
    assign blk_off  = 32'(page_idx[NODE_AW-2:0]) << PAGE_SHIFT;

    // Free walk: alignment to the node size and the bit that picks the child.
    assign blk_aligned = ((off_reg & (POOL_MASK >> depth_reg)) == 32'd0);
    assign off_sh      = off_reg >> (POOL_SHIFT - 1 - int'(depth_reg));

    // Sequencer and memory port control.
    always_comb begin
        state_next    = state_reg;
        clr_next      = clr_reg;
        node_next     = node_reg;
        depth_next    = depth_reg;
        tgt_next      = tgt_reg;
        off_next      = off_reg;
        res_addr_next = res_addr_reg;
        res_ok_next   = res_ok_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        m_addr_next   = m_addr_reg;
        m_ok_next     = m_ok_reg;
        mem_we        = 1'b0;
        mem_waddr     = node_reg;
        mem_wdata     = bpa_pkg::ST_DARK;
        mem_re        = 1'b0;
        mem_raddr     = node_reg;

        case (state_reg)
            S_CLR: begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = (clr_reg == ROOT_NODE) ? bpa_pkg::ST_FREE : bpa_pkg::ST_DARK;
                clr_next  = clr_reg + NODE_AW'(1);
                if (&clr_reg) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_tvalid) begin
                    res_addr_next = 32'd0;
                    res_ok_next   = 1'b0;
                    node_next     = ROOT_NODE;
                    depth_next    = '0;
                    if (s_tuser == bpa_pkg::FUNC_ALLOC) begin
                        tgt_next = LEAF_DEPTH - size_log;
                        if (in_req == '0 || 33'(in_req) > POOL_BYTES) begin
                            state_next = S_DONE;
                        end else begin
                            state_next = S_ARD;
                        end
                    end else begin
                        off_next = in_off;
                        if ({1'b0, in_off} >= POOL_BYTES) begin
                            state_next = S_DONE;
                        end else begin
                            state_next = S_FRD;
                        end
                    end
                end
            end
            // Depth-first search for a free node of the target size.
            S_ARD: begin
                mem_re     = 1'b1;
                state_next = S_AEV;
            end
            S_AEV: begin
                if (depth_reg == tgt_reg) begin
                    if (rd_reg == bpa_pkg::ST_FREE) begin
                        mem_we        = 1'b1;
                        mem_wdata     = bpa_pkg::ST_USED;
                        res_ok_next   = 1'b1;
                        res_addr_next = pool_base_reg + blk_off;
                        state_next    = S_DONE;
                    end else begin
                        state_next = S_ABT;
                    end
                end else if (rd_reg == bpa_pkg::ST_FREE) begin
                    mem_we     = 1'b1;
                    mem_wdata  = bpa_pkg::ST_SPLIT;
                    state_next = S_ASPL;
                end else if (rd_reg == bpa_pkg::ST_SPLIT) begin
                    node_next  = node_reg << 1;
                    depth_next = depth_reg + DEPTH_W'(1);
                    state_next = S_ARD;
                end else begin
                    state_next = S_ABT;
                end
            end
            S_ASPL: begin
                mem_we     = 1'b1;
                mem_waddr  = node_reg << 1;
                mem_wdata  = bpa_pkg::ST_FREE;
                state_next = S_ASPR;
            end
            S_ASPR: begin
                mem_we     = 1'b1;
                mem_waddr  = (node_reg << 1) | ROOT_NODE;
                mem_wdata  = bpa_pkg::ST_FREE;
                node_next  = node_reg << 1;
                depth_next = depth_reg + DEPTH_W'(1);
                state_next = S_ARD;
            end
            // Backtrack: a left child moves to its sibling, a right child climbs.
            S_ABT: begin
                if (node_reg == ROOT_NODE) begin
                    state_next = S_DONE;
                end else if (!node_reg[0]) begin
                    node_next  = node_reg | ROOT_NODE;
                    state_next = S_ARD;
                end else begin
                    node_next  = node_reg >> 1;
                    depth_next = depth_reg - DEPTH_W'(1);
                end
            end
            // Free: walk down by address to the used node.
            S_FRD: begin
                mem_re     = 1'b1;
                state_next = S_FEV;
            end
            S_FEV: begin
                if (blk_aligned && rd_reg == bpa_pkg::ST_USED) begin
                    mem_we      = 1'b1;
                    mem_wdata   = bpa_pkg::ST_FREE;
                    res_ok_next = 1'b1;
                    state_next  = S_MRD;
                end else if (depth_reg == LEAF_DEPTH) begin
                    state_next = S_DONE;
                end else begin
                    node_next  = {node_reg[NODE_AW-2:0], off_sh[0]};
                    depth_next = depth_reg + DEPTH_W'(1);
                    state_next = S_FRD;
                end
            end
            // Merge upward while the buddy is free.
            S_MRD: begin
                if (node_reg == ROOT_NODE) begin
                    state_next = S_DONE;
                end else begin
                    mem_re     = 1'b1;
                    mem_raddr  = node_reg ^ ROOT_NODE;
                    state_next = S_MEV;
                end
            end
            S_MEV: begin
                if (rd_reg == bpa_pkg::ST_FREE) begin
                    mem_we     = 1'b1;
                    mem_waddr  = node_reg ^ ROOT_NODE;
                    mem_wdata  = bpa_pkg::ST_DARK;
                    state_next = S_MDK;
                end else begin
                    state_next = S_DONE;
                end
            end
            S_MDK: begin
                mem_we     = 1'b1;
                mem_wdata  = bpa_pkg::ST_DARK;
                state_next = S_MUP;
            end
            S_MUP: begin
                mem_we     = 1'b1;
                mem_waddr  = node_reg >> 1;
                mem_wdata  = bpa_pkg::ST_FREE;
                node_next  = node_reg >> 1;
                depth_next = depth_reg - DEPTH_W'(1);
                state_next = S_MRD;
            end
            // Hand the result to the output register once it has room.
            S_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_addr_next  = res_addr_reg;
                    m_ok_next    = res_ok_reg;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_CLR;
                clr_next   = '0;
            end
        endcase
    end

    assign pool_base_next = cfg_wr_en ? cfg_wr_data : pool_base_reg;

    // Node-state memory with a registered read port.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            node_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rd_reg <= node_mem[mem_raddr];
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_CLR;
            clr_reg       <= '0;
            m_valid_reg   <= 1'b0;
            pool_base_reg <= bpa_pkg::POOL_BASE_RESET;
        end else begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            m_valid_reg   <= m_valid_next;
            pool_base_reg <= pool_base_next;
        end
    end

    // Working and payload registers.
    always_ff @(posedge aclk) begin
        node_reg     <= node_next;
        depth_reg    <= depth_next;
        tgt_reg      <= tgt_next;
        off_reg      <= off_next;
        res_addr_reg <= res_addr_next;
        res_ok_reg   <= res_ok_next;
        m_addr_reg   <= m_addr_next;
        m_ok_reg     <= m_ok_next;
    end

endmodule

`default_nettype wire

>>> sv/bpa_checker.sv
// Port-level checker for the buddy page allocator, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "buddy_page_allocator_top_defines.svh"

module bpa_checker (
    input wire logic                       aclk,
    input wire logic                       aresetn,
    input wire logic                       s_tvalid,
    input wire logic                       s_tready,
    input wire logic                       m_tvalid,
    input wire logic                       m_tready,
    input wire logic [bpa_pkg::ADDR_W-1:0] m_tdata,
    input wire logic                       m_tuser
);

    // A refused or failed transaction never carries an address.
    `BPA_ASSERT_IMP(a_fail_addr_zero, m_tvalid && !m_tuser, m_tdata == '0, "failed result with address")

    // Only one request is in work: ready drops after every accepted transaction.
    `BPA_ASSERT_NXT(a_one_in_work, s_tvalid && s_tready, !s_tready, "ready held after accept")

    // A stalled result stays put.
    `BPA_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

endmodule

bind buddy_page_allocator_top bpa_checker u_bpa_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire
